// ===== design/lcat_pkg.sv =====
// ----------------------------------------------------------------------------
// lcat_pkg
// Shared widths and controller state codes for the linked chunk allocation
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcat_pkg;

  localparam int KEY_PORT_W  = 64;
  localparam int DATA_PORT_W = 64;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_WALK     = 6'b001000,
    ST_PREV_RD  = 6'b010000,
    ST_PREV_CHK = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== design/linked_chunk_allocation_table_unit.sv =====
// ----------------------------------------------------------------------------
// linked_chunk_allocation_table_unit
// Slot table with per-name chunk chains, held in one entry RAM.
// Insert: scan for lowest free slot, one entry per cycle, then a read-modify-
//   write of the previous slot's link unless the free slot is that slot.
// Remove: scan for lowest matching slot, then walk its chain, freeing each
//   entry. Insert into a full table is refused without a scan.
// One transaction at a time; the result strobe lasts one cycle, no stall.
// Reset: synchronous clearing pass over all SLOTS entries with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_chunk_allocation_table_unit #(
  parameter int SLOTS     = 64,
  parameter int KEY_BITS  = 64,
  parameter int DATA_BITS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_action,
  input  wire logic [lcat_pkg::KEY_PORT_W-1:0]    in_name_key,
  input  wire logic [lcat_pkg::DATA_PORT_W-1:0]   in_chunk_data,
  output logic                                    out_strobe,
  output logic                                    out_ok,
  output logic [$clog2(SLOTS)-1:0]                out_slot_index,
  output logic [$clog2(SLOTS+1)-1:0]              out_freed_count,
  output logic [$clog2(SLOTS+1)-1:0]              out_used_count
);

  import lcat_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] NUM_SLOTS = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
    logic [CNT_W-1:0]     link;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  state_t               state_r, state_nxt;
  logic                 action_r, action_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_addr_r, chk_addr_nxt;
  logic [IDX_W-1:0]     walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     freed_r, freed_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [IDX_W-1:0]     last_r, last_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [IDX_W-1:0]     clr_addr_r, clr_addr_nxt;

  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [ENT_W-1:0]     rd_data;
  entry_t               rd_ent, wr_ent;

  logic                 emit_en, emit_ok;
  logic [IDX_W-1:0]     emit_idx;
  logic [CNT_W-1:0]     emit_freed;

  logic                 step_go, step_valid;
  logic [IDX_W-1:0]     step_idx, step_head;
  logic [CNT_W-1:0]     step_freed;

  assign rd_ent = entry_t'(rd_data);
  assign busy   = (state_r != ST_IDLE);

  lcat_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    scan_addr_nxt = scan_addr_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    walk_idx_nxt  = walk_idx_r;
    head_nxt      = head_r;
    freed_nxt     = freed_r;
    used_nxt      = used_r;
    last_nxt      = last_r;
    clr_addr_nxt  = clr_addr_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_ent        = '0;
    emit_en       = 1'b0;
    emit_ok       = 1'b0;
    emit_idx      = '0;
    emit_freed    = '0;
    step_go       = 1'b0;
    step_valid    = 1'b0;
    step_idx      = walk_idx_r;
    step_head     = head_r;
    step_freed    = freed_r;

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        if (clr_addr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (!in_action && (used_r >= NUM_SLOTS)) begin
            emit_en = 1'b1;
          end else begin
            action_nxt    = in_action;
            key_nxt       = in_name_key[KEY_BITS-1:0];
            data_nxt      = in_chunk_data[DATA_BITS-1:0];
            scan_addr_nxt = '0;
            freed_nxt     = '0;
            if (!in_action && (used_r == '0)) begin
              last_nxt = '0;
            end
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (scan_addr_r < NUM_SLOTS) begin
          rd_en         = 1'b1;
          rd_addr       = scan_addr_r[IDX_W-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_addr_nxt  = scan_addr_r[IDX_W-1:0];
        end
        if (chk_vld_r) begin
          if (!action_r && !rd_ent.valid) begin
            // free slot found
            wr_en        = 1'b1;
            wr_addr      = chk_addr_r;
            wr_ent.valid = 1'b1;
            wr_ent.key   = key_r;
            wr_ent.data  = data_r;
            wr_ent.link  = NUM_SLOTS;
            head_nxt     = chk_addr_r;
            chk_vld_nxt  = 1'b0;
            if (last_r == chk_addr_r) begin
              used_nxt   = used_r + 1'b1;
              emit_en    = 1'b1;
              emit_ok    = 1'b1;
              emit_idx   = chk_addr_r;
              state_nxt  = ST_IDLE;
            end else begin
              state_nxt  = ST_PREV_RD;
            end
          end else if (action_r && rd_ent.valid && (rd_ent.key == key_r)) begin
            // chain head found
            chk_vld_nxt = 1'b0;
            head_nxt    = chk_addr_r;
            step_go     = 1'b1;
            step_valid  = 1'b1;
            step_idx    = chk_addr_r;
            step_head   = chk_addr_r;
            step_freed  = '0;
          end else if (chk_addr_r == LAST_IDX) begin
            chk_vld_nxt = 1'b0;
            emit_en     = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end

      ST_WALK: begin
        step_go    = 1'b1;
        step_valid = rd_ent.valid && !fwd_r;
      end

      ST_PREV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = last_r;
        state_nxt = ST_PREV_CHK;
      end

      ST_PREV_CHK: begin
        if (rd_ent.valid) begin
          wr_en   = 1'b1;
          wr_addr = last_r;
          wr_ent  = rd_ent;
          wr_ent.link = (rd_ent.key == key_r) ? CNT_W'(head_r) : NUM_SLOTS;
        end
        last_nxt  = head_r;
        used_nxt  = used_r + 1'b1;
        emit_en   = 1'b1;
        emit_ok   = 1'b1;
        emit_idx  = head_r;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // one chain entry freed per cycle
    if (step_go) begin
      if (step_valid && (step_freed < NUM_SLOTS)) begin
        wr_en        = 1'b1;
        wr_addr      = step_idx;
        wr_ent       = rd_ent;
        wr_ent.valid = 1'b0;
        freed_nxt    = step_freed + 1'b1;
        if (used_r > '0) begin
          used_nxt = used_r - 1'b1;
        end
        if ((rd_ent.link < NUM_SLOTS) && (freed_nxt < NUM_SLOTS)) begin
          rd_en        = 1'b1;
          rd_addr      = rd_ent.link[IDX_W-1:0];
          walk_idx_nxt = rd_ent.link[IDX_W-1:0];
          state_nxt    = ST_WALK;
        end else begin
          emit_en    = 1'b1;
          emit_ok    = 1'b1;
          emit_idx   = step_head;
          emit_freed = freed_nxt;
          state_nxt  = ST_IDLE;
        end
      end else begin
        emit_en    = 1'b1;
        emit_ok    = 1'b1;
        emit_idx   = step_head;
        emit_freed = step_freed;
        state_nxt  = ST_IDLE;
      end
    end

    // read of the entry being written sees it as freed
    fwd_nxt = wr_en && rd_en && (rd_addr == wr_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      used_r     <= '0;
      last_r     <= '0;
      chk_vld_r  <= 1'b0;
      fwd_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      used_r     <= used_nxt;
      last_r     <= last_nxt;
      chk_vld_r  <= chk_vld_nxt;
      fwd_r      <= fwd_nxt;
      out_strobe <= emit_en;
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    key_r       <= key_nxt;
    data_r      <= data_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    walk_idx_r  <= walk_idx_nxt;
    head_r      <= head_nxt;
    freed_r     <= freed_nxt;
    if (emit_en) begin
      out_ok          <= emit_ok;
      out_slot_index  <= emit_idx;
      out_freed_count <= emit_freed;
      out_used_count  <= used_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lcat_ram.sv =====
// ----------------------------------------------------------------------------
// lcat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
